@@ rtl/uer_pkg.sv @@
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  // Default number of sensor channels
  localparam int CHANNELS_DEF = 6;

  localparam int CHAN_W = 4;
  localparam int TIME_W = 64;
  localparam int SPAN_W = 32;
  localparam int DIST_W = 22;

  // Speed of sound scaling: distance = ((span * 331) mod 2^32) / 2000
  localparam logic [8:0] SOUND_MUL = 9'd331;

  // Divide by 2000 = drop 4 bits, then divide by 125 with a reciprocal.
  // For a 28-bit x, x / 125 == (x * ceil(2^35 / 125)) >> 35.
  localparam int PRE_SHIFT   = 4;
  localparam int QUOT_IN_W   = SPAN_W - PRE_SHIFT;
  localparam int RECIP_W     = 29;
  localparam int RECIP_SHIFT = 35;
  localparam logic [RECIP_W-1:0] RECIP_125 = 29'd274877907;

  typedef enum logic [1:0] {
    FUNC_TRIGGER = 2'd0,
    FUNC_CLEAR   = 2'd1,
    FUNC_RISE    = 2'd2,
    FUNC_FALL    = 2'd3
  } uer_func_t;

  typedef struct packed {
    uer_func_t          func;
    logic [CHAN_W-1:0]  channel;
    logic [TIME_W-1:0]  now_us;
  } uer_in_t;

  // Outcome of the state update, before the distance arithmetic
  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic [SPAN_W-1:0]  span;
    logic               measured;
    logic               armed;
    logic               ignored;
  } uer_span_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  channel_out;
    logic [DIST_W-1:0]  distance_mm;
    logic               measured;
    logic               armed;
    logic               ignored;
  } uer_out_t;

endpackage

@@ rtl/uer_event_stage.sv @@
// ----------------------------------------------------------------------------
// uer_event_stage
// Per-channel state table: read, update and write back one event per cycle while sp is not stalled.
// ----------------------------------------------------------------------------
module uer_event_stage #(
  parameter int CHANNELS = uer_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              ev_valid,
  output logic              ev_ready,
  input  uer_pkg::uer_in_t   ev,
  output logic              sp_valid,
  input  logic              sp_ready,
  output uer_pkg::uer_span_t sp
);
  import uer_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W+1)'(CHANNELS);

  // The stored distance is kept as the echo span it was derived from;
  // a span of zero gives a distance of zero.
  logic              armed_flags [CHANNELS];
  logic [TIME_W-1:0] rise_time   [CHANNELS];
  logic [SPAN_W-1:0] echo_span   [CHANNELS];

  logic              in_range;
  logic [IDX_W-1:0]  idx;
  logic              take;
  logic              armed_cur;
  logic [TIME_W-1:0] rise_cur;
  logic [SPAN_W-1:0] span_cur;
  logic              armed_next;
  logic [TIME_W-1:0] rise_next;
  logic [SPAN_W-1:0] span_next;
  uer_span_t         sp_next;

  assign in_range = {1'b0, ev.channel} < CH_LIMIT;
  assign idx      = ev.channel[IDX_W-1:0];
  assign ev_ready = !sp_valid || sp_ready;
  assign take     = ev_valid && ev_ready;

  always_comb begin
    armed_cur  = 1'b0;
    rise_cur   = '0;
    span_cur   = '0;
    if (in_range) begin
      armed_cur = armed_flags[idx];
      rise_cur  = rise_time[idx];
      span_cur  = echo_span[idx];
    end

    armed_next       = armed_cur;
    rise_next        = rise_cur;
    span_next        = span_cur;
    sp_next.channel  = ev.channel;
    sp_next.measured = 1'b0;
    sp_next.ignored  = 1'b0;

    case (ev.func)
      FUNC_TRIGGER: begin
        armed_next = 1'b1;
        rise_next  = '0;
      end
      FUNC_CLEAR: begin
        armed_next = 1'b1;
        rise_next  = '0;
        span_next  = '0;
      end
      FUNC_RISE: begin
        if (!armed_cur) begin
          sp_next.ignored = 1'b1;
        end else begin
          rise_next = ev.now_us;
        end
      end
      FUNC_FALL: begin
        if (!armed_cur) begin
          sp_next.ignored = 1'b1;
        end else begin
          armed_next = 1'b0;
          if (ev.now_us > rise_cur && rise_cur != '0) begin
            span_next        = ev.now_us[SPAN_W-1:0] - rise_cur[SPAN_W-1:0];
            sp_next.measured = 1'b1;
          end
        end
      end
      default: begin
        sp_next.ignored = 1'b1;
      end
    endcase

    sp_next.span  = span_next;
    sp_next.armed = armed_next;

    if (!in_range) begin
      sp_next.span     = '0;
      sp_next.armed    = 1'b0;
      sp_next.measured = 1'b0;
      sp_next.ignored  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        armed_flags[i] <= 1'b0;
        rise_time[i]   <= '0;
        echo_span[i]   <= '0;
      end
    end else if (take && in_range) begin
      armed_flags[idx] <= armed_next;
      rise_time[idx]   <= rise_next;
      echo_span[idx]   <= span_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp_valid <= 1'b0;
    end else if (ev_ready) begin
      sp_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sp <= sp_next;
    end
  end

endmodule

@@ rtl/uer_range_calc.sv @@
// ----------------------------------------------------------------------------
// uer_range_calc
// Echo span to millimetres: scale by 331, then divide by 2000 by reciprocal.
// ----------------------------------------------------------------------------
module uer_range_calc (
  input  logic               clk,
  input  logic               rst,
  input  logic               sp_valid,
  output logic               sp_ready,
  input  uer_pkg::uer_span_t sp,
  output logic               res_valid,
  input  logic               res_ready,
  output uer_pkg::uer_out_t  res
);
  import uer_pkg::*;

  logic [SPAN_W+8:0]            prod_full;
  logic [SPAN_W-1:0]            prod;
  logic [QUOT_IN_W+RECIP_W-1:0] quot_full;

  // Scaled stage
  logic                 p_valid;
  logic                 p_ready;
  logic [CHAN_W-1:0]    p_channel;
  logic [QUOT_IN_W-1:0] p_scaled;
  logic                 p_measured;
  logic                 p_armed;
  logic                 p_ignored;

  // Product wraps at 32 bits, as the distance formula requires
  assign prod_full = {9'b0, sp.span} * {{SPAN_W{1'b0}}, SOUND_MUL};
  assign prod      = prod_full[SPAN_W-1:0];

  assign quot_full = {{RECIP_W{1'b0}}, p_scaled} * {{QUOT_IN_W{1'b0}}, RECIP_125};

  assign p_ready  = !res_valid || res_ready;
  assign sp_ready = !p_valid || p_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (sp_ready) begin
        p_valid <= sp_valid;
      end
      if (p_ready) begin
        res_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sp_valid && sp_ready) begin
      p_channel  <= sp.channel;
      p_scaled   <= prod[SPAN_W-1:PRE_SHIFT];
      p_measured <= sp.measured;
      p_armed    <= sp.armed;
      p_ignored  <= sp.ignored;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid && p_ready) begin
      res.channel_out <= p_channel;
      res.distance_mm <= quot_full[RECIP_SHIFT +: DIST_W];
      res.measured    <= p_measured;
      res.armed       <= p_armed;
      res.ignored     <= p_ignored;
    end
  end

endmodule

@@ rtl/ultrasonic_echo_ranger.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Multi-channel ultrasonic range timer: arms channels, times echoes and
// keeps one distance in millimetres per channel.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Carries
//   evt       evt_valid/evt_ready   func, channel, now_us (one event)
//   res       res_valid/res_ready   channel_out, distance_mm, measured,
//                                   armed, ignored (one result per event)
//
// One event is taken per cycle while res is not stalled; its result passes
// through the input register, state update, x331 scaling and divide by 2000.
// The four register stages set the latency; the read-modify-write of the
// channel table within the state stage keeps the rate at one per cycle.
// Reset (rst, synchronous) disarms all channels and zeroes rise times and
// stored distances. A stall on res backs up stage by stage; evt_ready only
// drops once every stage holds an item.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
  parameter int CHANNELS = uer_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              evt_valid,
  output logic              evt_ready,
  input  uer_pkg::uer_in_t  evt,
  output logic              res_valid,
  input  logic              res_ready,
  output uer_pkg::uer_out_t res
);
  import uer_pkg::*;

  // Input register: holds the accepted event until the state stage takes it
  logic      in_valid;
  logic      in_ready_down;
  uer_in_t   in_item;

  // Between state update and distance arithmetic
  logic      sp_valid;
  logic      sp_ready;
  uer_span_t sp;

  // Accept whenever the input register is empty or is being drained
  assign evt_ready = !in_valid || in_ready_down;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (evt_ready) begin
      in_valid <= evt_valid;
    end
  end

  // Payload: capture on acceptance only
  always_ff @(posedge clk) begin
    if (evt_valid && evt_ready) begin
      in_item <= evt;
    end
  end

  // Look up the channel, apply the event, write the channel back
  uer_event_stage #(
    .CHANNELS (CHANNELS)
  ) u_event (
    .clk      (clk),
    .rst      (rst),
    .ev_valid (in_valid),
    .ev_ready (in_ready_down),
    .ev       (in_item),
    .sp_valid (sp_valid),
    .sp_ready (sp_ready),
    .sp       (sp)
  );

  // Turn the stored echo span into millimetres and drive the result
  uer_range_calc u_calc (
    .clk       (clk),
    .rst       (rst),
    .sp_valid  (sp_valid),
    .sp_ready  (sp_ready),
    .sp        (sp),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

@@ verif/ultrasonic_echo_ranger_checker.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_checker
// Watches both channels of the echo ranger, predicts one reading per
// accepted event from a private copy of the channel table and compares
// every accepted reading, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_checker #(
  parameter int CHANNELS = uer_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              evt_valid,
  input  logic              evt_ready,
  input  uer_pkg::uer_in_t  evt,
  input  logic              res_valid,
  input  logic              res_ready,
  input  uer_pkg::uer_out_t res,
  output int                errors,
  output int                outstanding,
  output int                stored_count,
  output int                ignored_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import uer_pkg::*;

  localparam logic [SPAN_W-1:0] ECHO_SCALE = 32'd331;
  localparam logic [SPAN_W-1:0] MM_DIVISOR = 32'd1000;

  // private channel table
  logic              chan_armed [CHANNELS];
  logic [TIME_W-1:0] chan_rise  [CHANNELS];
  logic [DIST_W-1:0] chan_dist  [CHANNELS];

  uer_out_t expected_readings [$];

  // echo span in microseconds to millimetres, scaled product wraps at 32 bits
  function automatic logic [DIST_W-1:0] echo_mm(input logic [TIME_W-1:0] span);
    logic [SPAN_W-1:0] scaled;
    scaled = span[SPAN_W-1:0] * ECHO_SCALE;
    return DIST_W'((scaled / MM_DIVISOR) / 32'd2);
  endfunction

  function automatic uer_out_t predict_reading(input uer_in_t ev);
    uer_out_t r;
    int       ch;
    r = '0;
    r.channel_out = ev.channel;
    ch = int'(ev.channel);
    if (ch >= CHANNELS) begin
      r.ignored = 1'b1;
      return r;
    end
    case (ev.func)
      FUNC_TRIGGER, FUNC_CLEAR: begin
        chan_armed[ch] = 1'b1;
        chan_rise[ch]  = '0;
        if (ev.func == FUNC_CLEAR) chan_dist[ch] = '0;
      end
      default: begin
        if (!chan_armed[ch]) begin
          r.ignored = 1'b1;
        end else if (ev.func == FUNC_RISE) begin
          chan_rise[ch] = ev.now_us;
        end else begin
          // a zero rise time means no rise was seen
          if (ev.now_us > chan_rise[ch] && chan_rise[ch] != '0) begin
            chan_dist[ch] = echo_mm(ev.now_us - chan_rise[ch]);
            r.measured    = 1'b1;
          end
          chan_armed[ch] = 1'b0;
        end
      end
    endcase
    r.distance_mm = chan_dist[ch];
    r.armed       = chan_armed[ch];
    return r;
  endfunction

  always @(posedge clk) begin
    uer_out_t want;
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_armed[i] = 1'b0;
        chan_rise[i]  = '0;
        chan_dist[i]  = '0;
      end
      expected_readings.delete();
      errors        = 0;
      stored_count  = 0;
      ignored_count = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_readings.size() == 0) begin
          $error("reading for channel %0d arrived with nothing expected", res.channel_out);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          if (res.channel_out !== want.channel_out) begin
            $error("channel_out: expected %0d, got %0d", want.channel_out, res.channel_out);
            errors++;
          end
          if (res.distance_mm !== want.distance_mm) begin
            $error("distance_mm: expected %0d, got %0d", want.distance_mm, res.distance_mm);
            errors++;
          end
          if (res.measured !== want.measured) begin
            $error("measured: expected %0b, got %0b", want.measured, res.measured);
            errors++;
          end
          if (res.armed !== want.armed) begin
            $error("armed: expected %0b, got %0b", want.armed, res.armed);
            errors++;
          end
          if (res.ignored !== want.ignored) begin
            $error("ignored: expected %0b, got %0b", want.ignored, res.ignored);
            errors++;
          end
          if (want.measured) stored_count++;
          if (want.ignored) ignored_count++;
        end
      end
      if (evt_valid && evt_ready) expected_readings.push_back(predict_reading(evt));
    end
    outstanding = expected_readings.size();
  end

endmodule

@@ verif/ultrasonic_echo_ranger_tb.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_tb
// Drives event items into the echo ranger and lets the checker judge the
// readings. A short directed list covers the corner cases, then random
// trigger/rise/fall sequences with noise run under three idling regimes,
// with long receiver hold-offs that back the pipeline up into the input.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import uer_pkg::*;

  localparam int CHANNELS        = CHANNELS_DEF;
  localparam int ITEMS_PER_PHASE = 600;
  localparam int HOLD_OFF_CYCLES = 300;
  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 12;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     evt_valid = 1'b0;
  logic     evt_ready;
  uer_in_t  evt       = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  uer_out_t res;

  int errors;
  int outstanding;
  int stored_count;
  int ignored_count;

  int send_idle_pct     = 0;
  int recv_idle_pct     = 0;
  int hold_off_requests = 0;
  int hold_offs_served  = 0;
  int events_sent       = 0;
  int quiet_cycles      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ultrasonic_echo_ranger #(
    .CHANNELS (CHANNELS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ultrasonic_echo_ranger_checker #(
    .CHANNELS (CHANNELS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .evt_valid     (evt_valid),
    .evt_ready     (evt_ready),
    .evt           (evt),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .errors        (errors),
    .outstanding   (outstanding),
    .stored_count  (stored_count),
    .ignored_count (ignored_count)
  );

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((evt_valid && evt_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: drop ready at random, or hold it low for a long stretch when
  // the stimulus asks, so the pipeline fills and the input stalls.
  always begin
    @(negedge clk);
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_offs_served != hold_off_requests) begin
      hold_offs_served++;
      res_ready <= 1'b0;
      repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
    end else begin
      res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic logic [TIME_W-1:0] rand_time64();
    return {$urandom, $urandom};
  endfunction

  function automatic uer_in_t make_event(input uer_func_t func, input int ch,
                                         input logic [TIME_W-1:0] stamp);
    uer_in_t ev;
    ev.func    = func;
    ev.channel = CHAN_W'(ch);
    ev.now_us  = stamp;
    return ev;
  endfunction

  // Offer one item: idle at random first, then hold valid and payload
  // steady until the block takes it. Returns at the following falling edge.
  task automatic offer_event(input uer_in_t ev);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      evt_valid <= 1'b0;
      @(negedge clk);
    end
    evt_valid <= 1'b1;
    evt       <= ev;
    @(posedge clk);
    while (!evt_ready) @(posedge clk);
    if (int'(ev.channel) < CHANNELS) events_sent++;
    @(negedge clk);
  endtask

  // One ranging cycle on a random channel: arm, rise (sometimes twice, rarely
  // at time zero), fall after a span of varied size, sometimes a stray rise or fall.
  task automatic run_echo_sequence();
    int                ch;
    int                pick;
    logic [TIME_W-1:0] rise_at;
    logic [TIME_W-1:0] span;
    ch = $urandom_range(0, CHANNELS - 1);
    offer_event(make_event(($urandom_range(0, 7) == 0) ? FUNC_CLEAR : FUNC_TRIGGER, ch,
                           rand_time64()));
    pick = $urandom_range(0, 99);
    if (pick < 4)       rise_at = '0;
    else if (pick < 50) rise_at = TIME_W'($urandom);
    else                rise_at = rand_time64();
    if ($urandom_range(0, 7) == 0)
      offer_event(make_event(FUNC_RISE, ch, rand_time64()));
    offer_event(make_event(FUNC_RISE, ch, rise_at));
    pick = $urandom_range(0, 99);
    if (pick < 55)      span = TIME_W'($urandom_range(1, 40000));
    else if (pick < 75) span = TIME_W'($urandom);
    else if (pick < 85) span = '0 - TIME_W'($urandom_range(0, 1000));
    else                span = rand_time64();
    offer_event(make_event(FUNC_FALL, ch, rise_at + span));
    if ($urandom_range(0, 9) == 0)
      offer_event(make_event(uer_func_t'($urandom_range(2, 3)), ch, rand_time64()));
  endtask

  initial begin
    uer_in_t directed [$];
    int      target;

    // Hold reset from the start, then release it once for the whole run.
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Edges on unarmed channels, with the timestamp at both extremes
    directed.push_back(make_event(FUNC_RISE, 0, '1));
    directed.push_back(make_event(FUNC_FALL, CHANNELS - 1, '0));
    // Rise at time zero reads as no rise: the fall only disarms
    directed.push_back(make_event(FUNC_TRIGGER, 0, '0));
    directed.push_back(make_event(FUNC_RISE, 0, '0));
    directed.push_back(make_event(FUNC_FALL, 0, 64'd100));
    // Repeated rise overwrites the first, then a clean measurement
    directed.push_back(make_event(FUNC_TRIGGER, 1, 64'd5));
    directed.push_back(make_event(FUNC_RISE, 1, 64'd1000));
    directed.push_back(make_event(FUNC_RISE, 1, 64'd2000));
    directed.push_back(make_event(FUNC_FALL, 1, 64'd7831));
    // Shortest span at the top of the time range
    directed.push_back(make_event(FUNC_TRIGGER, 2, '1));
    directed.push_back(make_event(FUNC_RISE, 2, 64'hFFFF_FFFF_FFFF_FFFE));
    directed.push_back(make_event(FUNC_FALL, 2, '1));
    // Longest span: low 32 bits all but saturated, product wraps
    directed.push_back(make_event(FUNC_TRIGGER, 3, '0));
    directed.push_back(make_event(FUNC_RISE, 3, 64'd1));
    directed.push_back(make_event(FUNC_FALL, 3, '1));
    // Fall earlier than rise, then a stray fall on the now unarmed channel
    directed.push_back(make_event(FUNC_TRIGGER, 4, 64'd0));
    directed.push_back(make_event(FUNC_RISE, 4, 64'd500));
    directed.push_back(make_event(FUNC_FALL, 4, 64'd400));
    directed.push_back(make_event(FUNC_FALL, 4, 64'd900));
    // Clear drops a stored distance and arms the channel
    directed.push_back(make_event(FUNC_CLEAR, 1, 64'd8000));
    // Fall at the same time as the rise
    directed.push_back(make_event(FUNC_RISE, 1, 64'd10));
    directed.push_back(make_event(FUNC_FALL, 1, 64'd10));
    // Channels beyond the table, lowest and highest
    directed.push_back(make_event(FUNC_TRIGGER, CHANNELS, '1));
    directed.push_back(make_event(FUNC_FALL, 15, 64'd1234));
    foreach (directed[i]) offer_event(directed[i]);

    // Random phases: receiver idles more, then sender idles more, then neither.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 28; recv_idle_pct = 53; end
        1:       begin send_idle_pct = 53; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      if (phase != 1) hold_off_requests++;
      target = events_sent + ITEMS_PER_PHASE;
      while (events_sent < target) begin
        if ($urandom_range(0, 99) < 80)
          run_echo_sequence();
        else
          offer_event(make_event(uer_func_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                                 rand_time64()));
      end
    end
    evt_valid <= 1'b0;

    // Drain: wait for every predicted reading, then let the bench idle before the summary.
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d in-range events over three idling regimes and two hold-offs",
             events_sent);
    $display("readings with a stored distance: %0d, ignored events: %0d",
             stored_count, ignored_count);
    if (errors == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
